@@ sv/bvf_pkg.sv @@
package bvf_pkg;

    // payload limits
    localparam logic [11:0] MAX_LEN   = 12'd2048;
    localparam logic [7:0]  CHUNK_LEN = 8'd255;

    // header address registers
    localparam logic [47:0] SRC_ADDR_RESET = 48'hDEAD_BEEF_DEAD;
    localparam logic [47:0] BSS_ID_RESET   = 48'hA100_64E6_0B8B;
    localparam logic        CFG_SRC_ADDR   = 1'b0;
    localparam logic        CFG_BSS_ID     = 1'b1;

    // decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified beat handed from front to back
    typedef struct packed {
        logic       hdr;
        logic       elem;
        logic [7:0] elen;
        logic [7:0] data;
        logic       eof;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic        we;
        logic        index;
        logic [47:0] data;
    } t_cfg_wr;

endpackage

@@ sv/bvf_in_if.sv @@
interface bvf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [11:0] payload_length;

    modport source (output valid, output payload_byte, output payload_length, input ready);
    modport sink (input valid, input payload_byte, input payload_length, output ready);
endinterface

@@ sv/bvf_out_if.sv @@
interface bvf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic       end_of_frame;

    modport source (output valid, output tx_byte, output last_of_run, output end_of_frame,
                    input ready);
    modport sink (input valid, input tx_byte, input last_of_run, input end_of_frame,
                  output ready);
endinterface

@@ sv/bvf_front.sv @@
module bvf_front
    import bvf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    bvf_in_if.sink       i_in,
    input  t_q_stat      i_q_stat,
    output logic         o_push,
    output t_q_entry     o_entry
);

    logic [11:0] r_bp, n_bp;
    logic [11:0] r_len, n_len;
    logic [7:0]  r_cr, n_cr;

    logic        start;
    logic [11:0] len_in;
    logic [11:0] len_cur;
    logic [7:0]  cr_cur;
    logic [11:0] left;
    logic [7:0]  elen;
    logic [7:0]  cr_after;
    logic [11:0] bp_inc;
    logic        eof;

    assign i_in.ready = !i_q_stat.full;
    assign o_push     = i_in.valid && !i_q_stat.full;

    // classify the incoming beat against the frame state
    always_comb begin
        start  = (r_bp == 12'd0);
        len_in = (i_in.payload_length == 12'd0) ? 12'd1 : i_in.payload_length;
        if (len_in > MAX_LEN) begin
            len_in = MAX_LEN;
        end
        len_cur  = start ? len_in : r_len;
        cr_cur   = start ? 8'd0 : r_cr;
        left     = len_cur - r_bp;
        elen     = (left < {4'd0, CHUNK_LEN}) ? left[7:0] : CHUNK_LEN;
        cr_after = (cr_cur == 8'd0) ? elen : cr_cur;
        if (cr_after != 8'd0) begin
            cr_after = cr_after - 8'd1;
        end
        bp_inc = r_bp + 12'd1;
        eof    = (bp_inc >= len_cur) || (bp_inc == 12'd0);

        o_entry.hdr  = start;
        o_entry.elem = (cr_cur == 8'd0);
        o_entry.elen = elen;
        o_entry.data = i_in.payload_byte[7] ? 8'h3F : i_in.payload_byte;
        o_entry.eof  = eof;

        n_bp  = eof ? 12'd0 : bp_inc;
        n_cr  = eof ? 8'd0 : cr_after;
        n_len = len_cur;
    end

    // frame state advances on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp  <= 12'd0;
            r_len <= 12'd0;
            r_cr  <= 8'd0;
        end else if (o_push) begin
            r_bp  <= n_bp;
            r_len <= n_len;
            r_cr  <= n_cr;
        end
    end

endmodule

@@ sv/bvf_queue.sv @@
module bvf_queue
    import bvf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_stat   o_stat
);

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ sv/bvf_back.sv @@
module bvf_back
    import bvf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  t_q_entry  i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    bvf_out_if.source o_out
);

    localparam logic [5:0] PH_HDR_LAST = 6'd35;
    localparam logic [5:0] PH_TAG      = 6'd36;
    localparam logic [5:0] PH_LEN      = 6'd37;
    localparam logic [5:0] PH_DATA     = 6'd38;

    logic [47:0] r_src, r_bss;
    logic        r_mid;
    logic [5:0]  r_phase, n_phase;
    logic        r_o_valid;
    logic [7:0]  r_o_byte, n_o_byte;
    logic        r_o_last;
    logic        r_o_eof;

    logic [5:0]  cur_phase;
    logic        emit;

    // fixed beacon header, addresses sent msb first
    function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
                                            input logic [47:0] sa,
                                            input logic [47:0] bs);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h80;
            6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9: b = 8'hFF;
            6'd10:   b = sa[47:40];
            6'd11:   b = sa[39:32];
            6'd12:   b = sa[31:24];
            6'd13:   b = sa[23:16];
            6'd14:   b = sa[15:8];
            6'd15:   b = sa[7:0];
            6'd16:   b = bs[47:40];
            6'd17:   b = bs[39:32];
            6'd18:   b = bs[31:24];
            6'd19:   b = bs[23:16];
            6'd20:   b = bs[15:8];
            6'd21:   b = bs[7:0];
            6'd22:   b = 8'h40;
            6'd23:   b = 8'h43;
            6'd32:   b = 8'h64;
            6'd34:   b = 8'h11;
            6'd35:   b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // address registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= SRC_ADDR_RESET;
            r_bss <= BSS_ID_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_SRC_ADDR: r_src <= i_cfg.data;
                CFG_BSS_ID:   r_bss <= i_cfg.data;
                default:      r_src <= r_src;
            endcase
        end
    end

    // byte sequencer over the queue head
    always_comb begin
        if (r_mid) begin
            cur_phase = r_phase;
        end else if (i_head.hdr) begin
            cur_phase = 6'd0;
        end else if (i_head.elem) begin
            cur_phase = PH_TAG;
        end else begin
            cur_phase = PH_DATA;
        end

        emit  = !i_q_stat.empty && (!r_o_valid || o_out.ready);
        o_pop = emit && (cur_phase == PH_DATA);

        case (cur_phase)
            PH_TAG:  n_o_byte = 8'hDE;
            PH_LEN:  n_o_byte = i_head.elen;
            PH_DATA: n_o_byte = i_head.data;
            default: n_o_byte = hdr_byte(cur_phase, r_src, r_bss);
        endcase

        if (cur_phase == PH_HDR_LAST) begin
            n_phase = i_head.elem ? PH_TAG : PH_DATA;
        end else begin
            n_phase = cur_phase + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (emit) begin
            r_mid <= (cur_phase != PH_DATA);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_phase <= n_phase;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_byte <= n_o_byte;
            r_o_last <= (cur_phase == PH_DATA);
            r_o_eof  <= (cur_phase == PH_DATA) && i_head.eof;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.tx_byte      = r_o_byte;
    assign o_out.last_of_run  = r_o_last;
    assign o_out.end_of_frame = r_o_eof;

endmodule

@@ sv/beacon_vendor_ie_framer_unit.sv @@
// an accepted beat is queued; the sequencer then registers its item's first byte
// one payload beat per cycle unless the queue is full; the back-end byte sequencer
//   inserts 36 header bytes per frame and a tag and a length byte per vendor element
// a 4-entry queue between classifier and sequencer lets each side stall alone
// reset (synchronous, active low) clears frame state, queue and output; addresses
//   return to their default values
module beacon_vendor_ie_framer_unit
    import bvf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bvf_in_if.sink      i_in,
    bvf_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    t_q_entry front_entry;
    t_q_entry q_head;
    t_q_stat  q_stat;
    t_cfg_wr  cfg_wr;
    logic     q_push;
    logic     q_pop;

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    bvf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_entry  (front_entry)
    );

    bvf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bvf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    // frame end only on the last byte of an item
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.end_of_frame |-> o_out.last_of_run)
        else $error("end_of_frame without last_of_run");

    // sequencer never retires an entry from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // front never pushes into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

endmodule

@@ tb/bvf_frame_checker.sv @@
module bvf_frame_checker
    import bvf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bvf_in_if           in_mon,
    bvf_out_if          out_mon,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [7:0] ELEMENT_TAG = 8'hDE;
    localparam logic [7:0] SUBST_BYTE  = 8'h3F;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
        logic       end_of_frame;
    } t_frame_beat;

    // predicted frame bytes, oldest first
    t_frame_beat expected_bytes[$];

    // shadow of the address registers and frame state
    logic [47:0] src_addr;
    logic [47:0] bss_id;
    logic [11:0] pay_pos;
    logic [11:0] pay_len;
    logic [7:0]  elem_left;

    int error_total = 0;
    t_frame_beat got;
    t_frame_beat want;

    assign o_errors  = error_total;
    assign o_pending = expected_bytes.size();

    // fixed beacon header with both addresses msb first
    function automatic logic [7:0] header_byte(int unsigned idx);
        if (idx == 0) return 8'h80;
        if (idx < 4) return 8'h00;
        if (idx < 10) return 8'hFF;
        if (idx < 16) return src_addr[8*(15-idx) +: 8];
        if (idx < 22) return bss_id[8*(21-idx) +: 8];
        if (idx == 22) return 8'h40;
        if (idx == 23) return 8'h43;
        if (idx < 32) return 8'h00;
        case (idx)
            32: return 8'h64;
            33: return 8'h00;
            34: return 8'h11;
            default: return 8'h04;
        endcase
    endfunction

    // bytes caused by one payload beat
    task automatic predict_tx_bytes(input logic [7:0] data, input logic [11:0] len_field);
        logic [11:0] left;
        logic [7:0]  elen;
        t_frame_beat b;
        b = '0;
        // first beat of a frame: latch clamped length and emit the header
        if (pay_pos == 12'd0) begin
            if (len_field == 12'd0)
                pay_len = 12'd1;
            else if (len_field > MAX_LEN)
                pay_len = MAX_LEN;
            else
                pay_len = len_field;
            elem_left = 8'd0;
            for (int i = 0; i < 36; i++) begin
                b.tx_byte = header_byte(i);
                expected_bytes.push_back(b);
            end
        end
        // vendor element header before each chunk
        if (elem_left == 8'd0) begin
            left = pay_len - pay_pos;
            elen = (left < {4'h0, CHUNK_LEN}) ? left[7:0] : CHUNK_LEN;
            b.tx_byte = ELEMENT_TAG;
            expected_bytes.push_back(b);
            b.tx_byte = elen;
            expected_bytes.push_back(b);
            elem_left = elen;
        end
        // the payload byte itself, non-ascii replaced
        b.tx_byte     = (data >= 8'h80) ? SUBST_BYTE : data;
        b.last_of_run = 1'b1;
        if (elem_left != 8'd0)
            elem_left = elem_left - 8'd1;
        pay_pos = pay_pos + 12'd1;
        if (pay_pos >= pay_len || pay_pos == 12'd0) begin
            b.end_of_frame = 1'b1;
            pay_pos   = 12'd0;
            elem_left = 8'd0;
        end
        expected_bytes.push_back(b);
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_addr  = SRC_ADDR_RESET;
            bss_id    = BSS_ID_RESET;
            pay_pos   = 12'd0;
            pay_len   = 12'd0;
            elem_left = 8'd0;
            expected_bytes.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                got.tx_byte      = out_mon.tx_byte;
                got.last_of_run  = out_mon.last_of_run;
                got.end_of_frame = out_mon.end_of_frame;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output beat: tx_byte %h", got.tx_byte);
                    error_total++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %h, got %h",
                               want.tx_byte, got.tx_byte);
                        error_total++;
                    end
                    if (got.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, got.last_of_run);
                        error_total++;
                    end
                    if (got.end_of_frame !== want.end_of_frame) begin
                        $error("end_of_frame: expected %b, got %b",
                               want.end_of_frame, got.end_of_frame);
                        error_total++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_tx_bytes(in_mon.payload_byte, in_mon.payload_length);
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SRC_ADDR)
                    src_addr = i_cfg_data;
                else
                    bss_id = i_cfg_data;
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import bvf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_BEATS    = 120;
    localparam int LONG_TAIL_BEATS = 16;
    localparam int TAIL_CYCLES     = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [47:0] i_cfg_data;

    int error_count;
    int pending_count;
    int cycle_count = 0;
    int beats_sent  = 0;
    bit steady      = 1'b0;

    bvf_in_if  in_ch();
    bvf_out_if out_ch();

    beacon_vendor_ie_framer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bvf_frame_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output backpressure
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    function automatic logic [7:0] pick_payload_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom);
    endfunction

    function automatic logic [47:0] pick_address();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // one payload beat, with random gaps ahead of it
    task automatic send_beat(input logic [7:0] data, input logic [11:0] len_field);
        while (!steady && $urandom_range(0, 99) < 36) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.payload_byte   <= data;
        in_ch.payload_length <= len_field;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        beats_sent++;
    endtask

    // whole frame: length on the first beat, random length field afterwards
    task automatic send_frame(input logic [11:0] len_field);
        int unsigned n;
        if (len_field == 12'd0)
            n = 1;
        else if (len_field > MAX_LEN)
            n = MAX_LEN;
        else
            n = len_field;
        send_beat(pick_payload_byte(), len_field);
        for (int i = 1; i < n; i++)
            send_beat(pick_payload_byte(), 12'($urandom));
    endtask

    // drop valid and wait until every predicted byte has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_addresses(input logic [47:0] src, input logic [47:0] bss);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SRC_ADDR;
        i_cfg_data  <= src;
        @(posedge i_clk);
        i_cfg_index <= CFG_BSS_ID;
        i_cfg_data  <= bss;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int target;
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= CFG_SRC_ADDR;
        i_cfg_data           <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.payload_byte   <= '0;
        in_ch.payload_length <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default addresses: single-byte frames, zero length, mid-frame length change
        send_beat(8'h00, 12'd1);
        send_beat(8'hFF, 12'd0);
        send_beat(8'h7F, 12'd2);
        send_beat(8'h80, 12'hFFF);

        // address extremes
        wait_drained();
        set_addresses(48'h0, 48'hFFFF_FFFF_FFFF);
        send_beat(8'h41, 12'd3);
        send_beat(8'hC3, 12'd0);
        send_beat(8'h7E, 12'h800);

        wait_drained();
        set_addresses(48'hFFFF_FFFF_FFFF, 48'h0);
        send_beat(8'h20, 12'd5);
        send_beat(8'hAA, 12'hAAA);
        send_beat(8'h55, 12'h555);
        send_beat(8'h3F, 12'h000);
        send_beat(8'h01, 12'd1);

        // random short frames under random addresses, the last round with no gaps
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            set_addresses(pick_address(), pick_address());
            steady = (ph == 3);
            target = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < target) begin
                if ($urandom_range(0, 9) == 0)
                    send_frame(12'd0);
                else
                    send_frame(12'($urandom_range(1, 12)));
            end
        end

        // oversized length opens a long frame, left open at the end
        wait_drained();
        set_addresses(pick_address(), pick_address());
        send_beat(pick_payload_byte(), 12'hFFF);
        for (int i = 1; i < LONG_TAIL_BEATS; i++)
            send_beat(pick_payload_byte(), 12'($urandom));
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ beacon_vendor_ie_framer_unit.f @@
sv/bvf_pkg.sv
sv/bvf_in_if.sv
sv/bvf_out_if.sv
sv/bvf_front.sv
sv/bvf_queue.sv
sv/bvf_back.sv
sv/beacon_vendor_ie_framer_unit.sv
tb/bvf_frame_checker.sv
tb/tb_top.sv
